@@ hdl/tld_pkg.sv @@
// Shared types, constants and helper functions of the terminal line discipline.
`timescale 1ns / 1ps
package tld_pkg;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_CARET = 8'h5E;

   localparam int ECHO_MAX = 6;

   localparam logic [1:0] REG_INPUT_MODES   = 2'd0;
   localparam logic [1:0] REG_OUTPUT_MODES  = 2'd1;
   localparam logic [1:0] REG_LOCAL_MODES   = 2'd2;
   localparam logic [1:0] REG_CONTROL_CHARS = 2'd3;

   localparam logic [4:0]  INPUT_MODES_RST   = 5'd4;
   localparam logic [4:0]  OUTPUT_MODES_RST  = 5'd5;
   localparam logic [7:0]  LOCAL_MODES_RST   = 8'd223;
   localparam logic [62:0] CONTROL_CHARS_RST = 63'h0400_7F15_161A_1C03;

   typedef enum logic [1:0] {
      SRC_RAW   = 2'd0,
      SRC_FLUSH = 2'd1,
      SRC_ECHO  = 2'd2
   } src_type;

   typedef struct packed {
      logic    load;
      logic    decode;
      logic    produce;
      src_type sel;
      logic    finish;
      logic    fl_inc;
      logic    ec_adv;
      logic    ec_sub;
      logic    flushing;
      logic    idle;
   } cmd_type;

   typedef struct packed {
      logic       raw;
      logic       fl_done;
      logic       ec_done;
      logic [1:0] ec_n;
      logic       ec_sub;
      logic       out_free;
   } status_type;

   typedef struct packed {
      logic [1:0] n;
      logic [7:0] b0;
      logic [7:0] b1;
   } post_type;

   function automatic logic is_printable(input logic [7:0] b);
      return (b >= 8'h20 && b <= 8'h7E);
   endfunction

   // Output post-processing of one terminal byte: zero, one or two bytes.
   function automatic post_type post_map(input logic [4:0] om, input logic [7:0] b);
      post_type r;
      r.n  = 2'd1;
      r.b0 = b;
      r.b1 = CH_CR;
      if (om[0]) begin
         if (om[1] && b == CH_CR) begin
            r.n = 2'd0;
         end else if (om[2] && b == CH_NL) begin
            r.n  = 2'd2;
            r.b0 = CH_NL;
         end else if (om[3] && b == CH_CR) begin
            r.b0 = CH_NL;
         end else if (om[4] && b == CH_NL) begin
            r.b0 = CH_CR;
         end
      end
      return r;
   endfunction

endpackage

@@ hdl/terminal_line_discipline_unit.sv @@
// Terminal line discipline: keyboard input processing, line editing, echo, output mapping.
//
// Input channel req_*: one byte per transfer, req_tuser selects keyboard (0) or program (1).
// Result channel rsp_*: bytes for the reader (rsp_tuser 0) or the terminal (rsp_tuser 1),
// rsp_tlast marks the final byte caused by one input byte; an input may cause none.
// Configuration csr_*: mode registers and control characters, to be written only while idle;
// the block itself does not enforce this. One item is handled at a time. After the accepting
// cycle come a decode state, a state that sends a raw-mode byte (every item spends it),
// a flush that reads and then sends each line byte and finally finds the end of the line (the
// registered read of the line store sets this), an echo walk that sends each echoed byte, skips
// each echo character that output mapping drops and then finds the end of the echo list, and
// a closing state that releases the byte marked last.
// Reset returns the registers to their defaults and empties the line; stored bytes
// are not cleared. A stalled receiver holds rsp_* steady and the sequencer waits;
// no new input is taken until every result of the current item has been queued.
`timescale 1ns / 1ps
module terminal_line_discipline_unit #(
   parameter int LINE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tuser,   // channel
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_addr,
   input  logic [62:0] csr_wr_data
);

   tld_pkg::cmd_type    cmd;
   tld_pkg::status_type st;

   tld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   tld_dp #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .st          (st),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

@@ hdl/tld_ctrl.sv @@
// Sequencer of the line discipline: decode, raw byte, line flush, echo, finish.
`timescale 1ns / 1ps
module tld_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  tld_pkg::status_type st,
   output tld_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECODE = 7'b0000010,
      S_RAW    = 7'b0000100,
      S_FL_RD  = 7'b0001000,
      S_FL_WR  = 7'b0010000,
      S_ECHO   = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.sel      = tld_pkg::SRC_RAW;
      cmd.idle     = (state_ff == S_IDLE);
      cmd.flushing = (state_ff == S_FL_RD) || (state_ff == S_FL_WR);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = S_RAW;
         end
         S_RAW: begin
            if (!st.raw) begin
               state_in = S_FL_RD;
            end else if (st.out_free) begin
               cmd.produce = 1'b1;
               cmd.sel     = tld_pkg::SRC_RAW;
               state_in    = S_FL_RD;
            end
         end
         S_FL_RD: begin
            state_in = st.fl_done ? S_ECHO : S_FL_WR;
         end
         S_FL_WR: begin
            if (st.out_free) begin
               cmd.produce = 1'b1;
               cmd.sel     = tld_pkg::SRC_FLUSH;
               cmd.fl_inc  = 1'b1;
               state_in    = S_FL_RD;
            end
         end
         S_ECHO: begin
            if (st.ec_done) begin
               state_in = S_DONE;
            end else if (st.ec_n == 2'd0) begin
               cmd.ec_adv = 1'b1;
            end else if (st.out_free) begin
               cmd.produce = 1'b1;
               cmd.sel     = tld_pkg::SRC_ECHO;
               // The second byte of a pair closes this character.
               if (st.ec_n == 2'd1 || st.ec_sub) begin
                  cmd.ec_adv = 1'b1;
               end else begin
                  cmd.ec_sub = 1'b1;
               end
            end
         end
         S_DONE: begin
            if (st.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/tld_dp.sv @@
// Datapath: mode registers, input decode, line store, echo list and output stage.
`timescale 1ns / 1ps
module tld_dp #(
   parameter int LINE_DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  tld_pkg::cmd_type    cmd,
   output tld_pkg::status_type st,
   input  logic                req_tuser,
   input  logic [7:0]          req_tdata,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_addr,
   input  logic [62:0]         csr_wr_data,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tuser,
   output logic                rsp_tlast
);

   localparam int IW = $clog2(LINE_DEPTH);
   localparam int CW = $clog2(LINE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);

   logic [4:0]  imodes_ff, omodes_ff;
   logic [7:0]  lmodes_ff;
   logic [62:0] cchars_ff;

   logic        func_ff;
   logic [7:0]  byte_ff;
   logic [CW-1:0] count_ff, count_in;
   logic        lit_ff, lit_in;
   logic        raw_ff, raw_in;
   logic [7:0]  rawb_ff, rawb_in;
   logic [CW-1:0] flen_ff, flen_in;
   logic [CW-1:0] fl_idx_ff;
   logic [2:0]  elen_ff, elen_in;
   logic [7:0]  ech_ff [tld_pkg::ECHO_MAX];
   logic [7:0]  ech_in [tld_pkg::ECHO_MAX];
   logic [2:0]  ek_ff;
   logic        es_ff;
   logic        wr_en;

   logic [7:0]  mem [LINE_DEPTH];
   logic [7:0]  rd_data_ff;
   logic [IW-1:0] rd_addr;

   logic        hold_v_ff;
   logic        hold_chan_ff;
   logic [7:0]  hold_byte_ff;
   logic        rsp_v_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_chan_ff, rsp_last_ff;

   logic [7:0]  cur_ch;
   tld_pkg::post_type pm;
   logic [7:0]  new_byte;
   logic        push;

   logic [7:0] cc [8];
   always_comb begin
      for (int k = 0; k < 7; k++) begin
         cc[k] = cchars_ff[8*k +: 8];
      end
      cc[7] = {1'b0, cchars_ff[62:56]};
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         imodes_ff <= tld_pkg::INPUT_MODES_RST;
         omodes_ff <= tld_pkg::OUTPUT_MODES_RST;
         lmodes_ff <= tld_pkg::LOCAL_MODES_RST;
         cchars_ff <= tld_pkg::CONTROL_CHARS_RST;
      end else if (csr_wr_en) begin
         case (csr_addr)
            tld_pkg::REG_INPUT_MODES:   imodes_ff <= csr_wr_data[4:0];
            tld_pkg::REG_OUTPUT_MODES:  omodes_ff <= csr_wr_data[4:0];
            tld_pkg::REG_LOCAL_MODES:   lmodes_ff <= csr_wr_data[7:0];
            tld_pkg::REG_CONTROL_CHARS: cchars_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // Input decode, evaluated in the decode cycle.
   always_comb begin
      logic [7:0] b;
      logic       go;
      logic       echo;
      logic       rub;
      logic       dbl;
      logic       kill;
      logic       erase;
      logic       term;
      logic [CW-1:0] cnt_s;
      b        = imodes_ff[0] ? {1'b0, byte_ff[6:0]} : byte_ff;
      go       = (byte_ff != 8'h00);
      echo     = 1'b0;
      rub      = 1'b0;
      dbl      = 1'b0;
      kill     = 1'b0;
      erase    = 1'b0;
      term     = 1'b0;
      cnt_s    = count_ff;
      lit_in   = lit_ff;
      count_in = count_ff;
      raw_in   = 1'b0;
      flen_in  = '0;
      elen_in  = 3'd0;
      wr_en    = 1'b0;
      for (int k = 0; k < tld_pkg::ECHO_MAX; k++) begin
         ech_in[k] = tld_pkg::CH_BS;
      end
      if (byte_ff != 8'h00) begin
         if (lit_ff) begin
            lit_in = 1'b0;
         end else if (lmodes_ff[0] && (b == cc[0] || b == cc[1] || b == cc[2])) begin
            lit_in = 1'b0;
         end else if (b == cc[3] && lmodes_ff[7]) begin
            lit_in = 1'b1;
         end else begin
            if (imodes_ff[1] && b == tld_pkg::CH_CR) begin
               go = 1'b0;
            end
            if (imodes_ff[2] && b == tld_pkg::CH_CR) begin
               b = tld_pkg::CH_NL;
            end else if (imodes_ff[3] && b == tld_pkg::CH_NL) begin
               b = tld_pkg::CH_CR;
            end
            if (imodes_ff[4] && b >= 8'h41 && b <= 8'h5A) begin
               b = b + 8'h20;
            end
         end
      end
      if (b == 8'h00) begin
         go = 1'b0;
      end
      rawb_in = b;

      if (func_ff) begin
         lit_in    = lit_ff;
         elen_in   = 3'd1;
         ech_in[0] = byte_ff;
      end else if (go) begin
         echo = lmodes_ff[2];
         if (lmodes_ff[1]) begin
            kill  = (b == cc[4]);
            erase = !kill && (b == cc[5]);
            if (kill) begin
               count_in = '0;
               echo     = echo && !lmodes_ff[4];
            end else if (erase) begin
               if (count_ff == '0) begin
                  echo = 1'b0;
               end else begin
                  count_in = count_ff - 1'b1;
                  rub      = lmodes_ff[2] && lmodes_ff[3];
                  dbl      = !tld_pkg::is_printable(rd_data_ff) &&
                             (rd_data_ff != tld_pkg::CH_NL);
                  echo     = echo && !lmodes_ff[3];
               end
            end else begin
               wr_en    = (count_ff < DEPTH_C);
               cnt_s    = wr_en ? count_ff + 1'b1 : count_ff;
               count_in = cnt_s;
               term     = (b == tld_pkg::CH_NL) || (b == cc[6]) || (b == cc[7]);
               if (term) begin
                  flen_in  = cnt_s;
                  count_in = '0;
                  echo     = echo || lmodes_ff[5];
               end
            end
         end else begin
            raw_in = 1'b1;
         end
         if (rub) begin
            // Backspace, space, backspace; twice for a control character.
            elen_in = dbl ? 3'd6 : 3'd3;
            ech_in[1] = tld_pkg::CH_SP;
            ech_in[4] = tld_pkg::CH_SP;
         end else if (echo) begin
            if (tld_pkg::is_printable(b) || b == tld_pkg::CH_NL || !lmodes_ff[6]) begin
               elen_in   = 3'd1;
               ech_in[0] = b;
            end else begin
               elen_in   = 3'd2;
               ech_in[0] = tld_pkg::CH_CARET;
               ech_in[1] = b ^ 8'h40;
            end
         end
      end
   end

   // Item and sequencing registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         lit_ff    <= 1'b0;
         raw_ff    <= 1'b0;
         flen_ff   <= '0;
         fl_idx_ff <= '0;
         elen_ff   <= 3'd0;
         ek_ff     <= 3'd0;
         es_ff     <= 1'b0;
      end else begin
         if (cmd.decode) begin
            count_ff  <= count_in;
            lit_ff    <= lit_in;
            raw_ff    <= raw_in;
            flen_ff   <= flen_in;
            fl_idx_ff <= '0;
            elen_ff   <= elen_in;
            ek_ff     <= 3'd0;
            es_ff     <= 1'b0;
         end
         if (cmd.fl_inc) begin
            fl_idx_ff <= fl_idx_ff + 1'b1;
         end
         if (cmd.ec_adv) begin
            ek_ff <= ek_ff + 3'd1;
            es_ff <= 1'b0;
         end else if (cmd.ec_sub) begin
            es_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_tuser;
         byte_ff <= req_tdata;
      end
      if (cmd.decode) begin
         rawb_ff <= rawb_in;
         for (int k = 0; k < tld_pkg::ECHO_MAX; k++) begin
            ech_ff[k] <= ech_in[k];
         end
      end
   end

   // Line store: one write port, one registered read port.
   assign rd_addr = cmd.flushing ? fl_idx_ff[IW-1:0] : IW'(count_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (cmd.decode && wr_en) begin
         mem[count_ff[IW-1:0]] <= rawb_in;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Echo character under the cursor and its post-processed bytes.
   assign cur_ch = (ek_ff < 3'(tld_pkg::ECHO_MAX)) ? ech_ff[ek_ff] : 8'h00;
   assign pm     = tld_pkg::post_map(omodes_ff, cur_ch);

   always_comb begin
      case (cmd.sel)
         tld_pkg::SRC_RAW:   new_byte = rawb_ff;
         tld_pkg::SRC_FLUSH: new_byte = rd_data_ff;
         tld_pkg::SRC_ECHO:  new_byte = es_ff ? pm.b1 : pm.b0;
         default:            new_byte = 8'h00;
      endcase
   end

   // One byte waits in the hold stage so the final one can be marked last.
   assign push = hold_v_ff && (cmd.produce || cmd.finish);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         if (cmd.produce) begin
            hold_v_ff <= 1'b1;
         end else if (cmd.finish) begin
            hold_v_ff <= 1'b0;
         end
         if (push) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.produce) begin
         hold_byte_ff <= new_byte;
         hold_chan_ff <= (cmd.sel == tld_pkg::SRC_ECHO);
      end
      if (push) begin
         rsp_byte_ff <= hold_byte_ff;
         rsp_chan_ff <= hold_chan_ff;
         rsp_last_ff <= cmd.finish;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_chan_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign st.raw      = raw_ff;
   assign st.fl_done  = (fl_idx_ff == flen_ff);
   assign st.ec_done  = (ek_ff == elen_ff);
   assign st.ec_n     = pm.n;
   assign st.ec_sub   = es_ff;
   assign st.out_free = !rsp_v_ff || rsp_tready;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("line count above store depth");
   a_flush_bound: assert property (@(posedge clock) disable iff (reset)
      fl_idx_ff <= flen_ff)
      else $error("flush index ran past the line length");
   a_echo_bound: assert property (@(posedge clock) disable iff (reset)
      ek_ff <= elen_ff && elen_ff <= 3'(tld_pkg::ECHO_MAX))
      else $error("echo index ran past the echo list");
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.idle |-> !hold_v_ff)
      else $error("held byte left over after an item finished");

endmodule
